@@ sv/sedf_pkg.sv @@
// Shared constants, phase and verdict codes and the result record type
// for the STX/ETX packet deframer. No dependencies.
package sedf_pkg;

   localparam int unsigned MAX_PAYLOAD = 1024;

   localparam logic [7:0]  STX_BYTE      = 8'h02;
   localparam logic [7:0]  ETX_BYTE      = 8'h03;
   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam logic [10:0] MAXLEN_RESET  = 11'd1024;
   localparam logic [16:0] IDLE_MAX      = 17'h1FFFF;
   localparam logic [10:0] LEN_SAT       = 11'h7FF;
   localparam logic [10:0] PAYLOAD_CAP   = 11'(MAX_PAYLOAD);

   // configuration register indexes
   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_MAXLEN  = 1'b1;

   // input actions
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // parser phases
   localparam logic [2:0] PH_STX   = 3'd0;
   localparam logic [2:0] PH_CMD   = 3'd1;
   localparam logic [2:0] PH_OPT   = 3'd2;
   localparam logic [2:0] PH_LEN_L = 3'd3;
   localparam logic [2:0] PH_LEN_H = 3'd4;
   localparam logic [2:0] PH_DATA  = 3'd5;
   localparam logic [2:0] PH_SUM   = 3'd6;
   localparam logic [2:0] PH_ETX   = 3'd7;

   // result kinds
   localparam logic [1:0] K_DATA   = 2'd0;
   localparam logic [1:0] K_ACCEPT = 2'd1;
   localparam logic [1:0] K_REJECT = 2'd2;
   localparam logic [1:0] K_ABORT  = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [9:0]  data_index;
      logic [7:0]  command;
      logic [7:0]  option;
      logic [10:0] length;
   } rsp_type;

endpackage

@@ sv/stx_etx_packet_deframer.sv @@
// STX/ETX packet deframer top level: parser state, idle timer and a
// two-entry result buffer. Depends on sedf_pkg.
//
// Usage:
//   The req channel carries one beat per received serial byte
//   (req_action = 0) or per one-millisecond tick (req_action = 1).
//   The rsp channel carries at most one result beat per req beat: a
//   payload byte with its index, or an accepted / rejected / aborted
//   verdict with the command, option and length of the packet.
//   The csr port writes timeout_ms (index 0) and max_length (index 1); the
//   user must write it only while the block is idle, which is not enforced.
// Throughput:
//   Each accepted req beat updates the parser state registers; its result is
//   registered into the main entry that drives rsp, or into the skid entry
//   while main waits. One req beat is taken every cycle while skid is empty.
// Reset:
//   Synchronous reset returns the parser to waiting for STX, clears the
//   idle timer and held fields and restores timeout 500 and max_length 1024.
// Stall:
//   A result waiting on rsp does not block req: a second result lands in a
//   skid entry, and req_ready drops only while that skid entry is full.
module stx_etx_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [9:0]  rsp_data_index,
   output logic [7:0]  rsp_command,
   output logic [7:0]  rsp_option,
   output logic [10:0] rsp_length,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wr_data
);
   import sedf_pkg::*;

   // configuration
   logic [15:0] timeout_ff, timeout_in;
   logic [10:0] maxlen_ff, maxlen_in;

   // parser state
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  opt_ff, opt_in;
   logic [10:0] len_ff, len_in;    // saturated at 2047
   logic [10:0] count_ff, count_in;
   logic [7:0]  sum_ff, sum_in;
   logic [16:0] idle_ff, idle_in;

   // result buffer
   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;

   logic        accept, take, timed_out, emit, res_valid;
   logic [2:0]  cur_phase;
   logic [10:0] limit, new_len, count_inc;
   rsp_type     res;

   assign accept = req_valid && req_ready;
   assign take   = main_valid_ff && rsp_ready;

   assign req_ready = !skid_valid_ff;

   assign limit     = (maxlen_ff < PAYLOAD_CAP) ? maxlen_ff : PAYLOAD_CAP;
   assign timed_out = idle_ff > {1'b0, timeout_ff};
   // high length byte of 8 or more puts the length past 2047: saturate
   assign new_len   = (req_rx_byte[7:3] != 5'd0) ? LEN_SAT : {req_rx_byte[2:0], len_ff[7:0]};
   assign count_inc = count_ff + 11'd1;

   // config writes
   always_comb begin
      timeout_in = timeout_ff;
      maxlen_in  = maxlen_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TIMEOUT: timeout_in = csr_wr_data;
            CSR_MAXLEN:  maxlen_in  = csr_wr_data[10:0];
            default:     timeout_in = timeout_ff;
         endcase
      end
   end

   // parser update for one beat
   always_comb begin
      phase_in = phase_ff;
      xor_in   = xor_ff;
      cmd_in   = cmd_ff;
      opt_in   = opt_ff;
      len_in   = len_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      idle_in  = idle_ff;
      emit     = 1'b0;
      res      = '{kind: K_ABORT, data_byte: 8'd0, data_index: 10'd0,
                   command: cmd_ff, option: opt_ff, length: len_ff};
      cur_phase = timed_out ? PH_STX : phase_ff;

      if (accept) begin
         if (req_action == ACT_TICK) begin
            if (idle_ff < IDLE_MAX) idle_in = idle_ff + 17'd1;
         end else begin
            idle_in = 17'd0;
            // a late byte drops any partial packet before it is parsed
            if (timed_out && phase_ff != PH_STX) emit = 1'b1;
            phase_in = cur_phase;
            unique case (cur_phase)
               PH_STX: begin
                  if (req_rx_byte == STX_BYTE) begin
                     phase_in = PH_CMD;
                     xor_in   = 8'd0;
                     len_in   = 11'd0;
                     count_in = 11'd0;
                  end
               end
               PH_CMD: begin
                  cmd_in   = req_rx_byte;
                  xor_in   = xor_ff ^ req_rx_byte;
                  phase_in = PH_OPT;
               end
               PH_OPT: begin
                  opt_in   = req_rx_byte;
                  xor_in   = xor_ff ^ req_rx_byte;
                  phase_in = PH_LEN_L;
               end
               PH_LEN_L: begin
                  len_in   = {3'd0, req_rx_byte};
                  xor_in   = xor_ff ^ req_rx_byte;
                  phase_in = PH_LEN_H;
               end
               PH_LEN_H: begin
                  len_in = new_len;
                  xor_in = xor_ff ^ req_rx_byte;
                  if (new_len > limit) begin
                     phase_in   = PH_STX;
                     emit       = 1'b1;
                     res.length = new_len;
                  end else if (new_len != 11'd0) begin
                     count_in = 11'd0;
                     phase_in = PH_DATA;
                  end else begin
                     phase_in = PH_SUM;
                  end
               end
               PH_DATA: begin
                  xor_in         = xor_ff ^ req_rx_byte;
                  emit           = 1'b1;
                  res.kind       = K_DATA;
                  res.data_byte  = req_rx_byte;
                  res.data_index = count_ff[9:0];
                  count_in       = count_inc;
                  if (count_inc >= len_ff) phase_in = PH_SUM;
               end
               PH_SUM: begin
                  sum_in   = req_rx_byte;
                  phase_in = PH_ETX;
               end
               PH_ETX: begin
                  emit     = 1'b1;
                  res.kind = (req_rx_byte == ETX_BYTE && sum_ff == xor_ff) ? K_ACCEPT
                                                                           : K_REJECT;
                  phase_in = PH_STX;
               end
               default: phase_in = PH_STX;
            endcase
         end
      end
   end

   assign res_valid = accept && emit;

   // result buffer: main entry drives rsp, skid catches a result during a stall
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = res;
            main_valid_in = res_valid;
         end
      end else if (res_valid) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         maxlen_ff     <= MAXLEN_RESET;
         phase_ff      <= PH_STX;
         xor_ff        <= 8'd0;
         cmd_ff        <= 8'd0;
         opt_ff        <= 8'd0;
         len_ff        <= 11'd0;
         count_ff      <= 11'd0;
         sum_ff        <= 8'd0;
         idle_ff       <= 17'd0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         timeout_ff    <= timeout_in;
         maxlen_ff     <= maxlen_in;
         phase_ff      <= phase_in;
         xor_ff        <= xor_in;
         cmd_ff        <= cmd_in;
         opt_ff        <= opt_in;
         len_ff        <= len_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         idle_ff       <= idle_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload of the buffer needs no reset
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = main_valid_ff;
   assign rsp_kind       = main_ff.kind;
   assign rsp_data_byte  = main_ff.data_byte;
   assign rsp_data_index = main_ff.data_index;
   assign rsp_command    = main_ff.command;
   assign rsp_option     = main_ff.option;
   assign rsp_length     = main_ff.length;

`ifndef SYNTHESIS
   // skid entry only fills behind a waiting main entry
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry valid without main entry");

   // any accepted byte restarts the idle timer
   a_idle_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_BYTE) |=> idle_ff == 17'd0)
      else $error("idle timer not cleared by a byte");

   // a payload byte always lies inside the packet length
   a_index_in_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == K_DATA) |-> {1'b0, rsp_data_index} < rsp_length)
      else $error("data index outside packet length");
`endif

endmodule

@@ test/sedf_frame_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the STX/ETX packet deframer: follows req, rsp and csr beats,
// predicts the results and compares them. Depends on sedf_pkg.
module sedf_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_kind,
   input  logic [7:0]  rsp_data_byte,
   input  logic [9:0]  rsp_data_index,
   input  logic [7:0]  rsp_command,
   input  logic [7:0]  rsp_option,
   input  logic [10:0] rsp_length,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wr_data,
   output int          fail_count,
   output int          pending
);
   import sedf_pkg::*;

   // register copies
   logic [15:0] timeout_ms;
   logic [10:0] max_len;

   // parser state
   logic [2:0]  phase;
   logic [7:0]  run_xor;
   logic [7:0]  cmd_held;
   logic [7:0]  opt_held;
   logic [15:0] pay_len;
   logic [10:0] byte_cnt;
   logic [7:0]  rx_sum;
   logic [16:0] idle_ms;

   rsp_type frame_events[$];
   int      errors = 0;

   assign fail_count = errors;

   function automatic rsp_type make_event(input logic [1:0] kind, input logic [7:0] db,
                                          input logic [9:0] di);
      rsp_type ev;
      ev.kind       = kind;
      ev.data_byte  = db;
      ev.data_index = di;
      ev.command    = cmd_held;
      ev.option     = opt_held;
      ev.length     = (pay_len > 16'(LEN_SAT)) ? LEN_SAT : pay_len[10:0];
      return ev;
   endfunction

   // advance the parser by one accepted req beat
   task automatic parse_beat(input logic act, input logic [7:0] b);
      logic [10:0] lim;
      lim = (max_len < PAYLOAD_CAP) ? max_len : PAYLOAD_CAP;
      if (act == ACT_TICK) begin
         if (idle_ms != IDLE_MAX) idle_ms++;
      end else begin
         // a late byte drops a partial packet before it is parsed itself
         if (idle_ms > {1'b0, timeout_ms}) begin
            if (phase != PH_STX) frame_events.push_back(make_event(K_ABORT, 8'h00, 10'd0));
            phase = PH_STX;
         end
         idle_ms = '0;
         case (phase)
            PH_STX: begin
               if (b == STX_BYTE) begin
                  phase    = PH_CMD;
                  run_xor  = 8'h00;
                  pay_len  = 16'd0;
                  byte_cnt = 11'd0;
               end
            end
            PH_CMD: begin
               cmd_held = b;
               run_xor ^= b;
               phase    = PH_OPT;
            end
            PH_OPT: begin
               opt_held = b;
               run_xor ^= b;
               phase    = PH_LEN_L;
            end
            PH_LEN_L: begin
               pay_len  = {8'h00, b};
               run_xor ^= b;
               phase    = PH_LEN_H;
            end
            PH_LEN_H: begin
               pay_len[15:8] = b;
               run_xor ^= b;
               if (pay_len > {5'b0, lim}) begin
                  phase = PH_STX;
                  frame_events.push_back(make_event(K_ABORT, 8'h00, 10'd0));
               end else if (pay_len != 16'd0) begin
                  byte_cnt = 11'd0;
                  phase    = PH_DATA;
               end else begin
                  phase = PH_SUM;
               end
            end
            PH_DATA: begin
               run_xor ^= b;
               frame_events.push_back(make_event(K_DATA, b, byte_cnt[9:0]));
               byte_cnt++;
               if ({5'b0, byte_cnt} >= pay_len) phase = PH_SUM;
            end
            PH_SUM: begin
               rx_sum = b;
               phase  = PH_ETX;
            end
            default: begin
               if (b == ETX_BYTE && rx_sum == run_xor)
                  frame_events.push_back(make_event(K_ACCEPT, 8'h00, 10'd0));
               else
                  frame_events.push_back(make_event(K_REJECT, 8'h00, 10'd0));
               phase = PH_STX;
            end
         endcase
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: rsp %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         timeout_ms = TIMEOUT_RESET;
         max_len    = MAXLEN_RESET;
         phase      = PH_STX;
         run_xor    = 8'h00;
         cmd_held   = 8'h00;
         opt_held   = 8'h00;
         pay_len    = 16'd0;
         byte_cnt   = 11'd0;
         rx_sum     = 8'h00;
         idle_ms    = 17'd0;
         frame_events.delete();
      end else begin
         // a result is registered after its req beat is parsed, so compare first
         if (rsp_valid && rsp_ready) begin
            if (frame_events.size() == 0) begin
               $display("%0t ns: rsp beat with nothing expected, kind %0d", $time, rsp_kind);
               errors++;
            end else begin
               want = frame_events.pop_front();
               check_field("kind", 16'(want.kind), 16'(rsp_kind));
               check_field("data_byte", 16'(want.data_byte), 16'(rsp_data_byte));
               check_field("data_index", 16'(want.data_index), 16'(rsp_data_index));
               check_field("command", 16'(want.command), 16'(rsp_command));
               check_field("option", 16'(want.option), 16'(rsp_option));
               check_field("length", 16'(want.length), 16'(rsp_length));
            end
         end
         if (csr_wr_en) begin
            if (csr_index == CSR_TIMEOUT) timeout_ms = csr_wr_data;
            else max_len = csr_wr_data[10:0];
         end
         if (req_valid && req_ready) parse_beat(req_action, req_rx_byte);
      end
      pending = frame_events.size();
   end

endmodule

@@ test/tb_stx_etx_packet_deframer.sv @@
`timescale 1ns / 100ps
// Top of the STX/ETX packet deframer testbench: clock, reset, framed byte stimulus,
// random backpressure and verdict. Depends on sedf_pkg and sedf_frame_checker.
module tb_stx_etx_packet_deframer;
   import sedf_pkg::*;

   // Longest correct stretch without any accepted beat is the long rsp hold-off
   // (PRESSURE_CYCLES) plus stimulus idling; allow several times that.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRESSURE_CYCLES = 300;

   typedef enum logic [1:0] {FLAW_NONE, FLAW_SUM, FLAW_ETX, FLAW_CUT} flaw_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_action;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [9:0]  rsp_data_index;
   logic [7:0]  rsp_command;
   logic [7:0]  rsp_option;
   logic [10:0] rsp_length;
   logic        csr_wr_en;
   logic        csr_index;
   logic [15:0] csr_wr_data;

   int fail_count;
   int pending;

   // stimulus view of the registers, used only to shape the frames
   logic [15:0] cur_timeout = TIMEOUT_RESET;
   logic [15:0] cur_lim = 16'd1024;
   int tick_pct = 0;           // chance of a tick run in front of a frame byte
   int tick_span = 3;          // longest such tick run
   int byte_beats = 0;         // frame bytes sent, the measure of the random part
   bit no_idle = 1'b0;         // both sides run flat out while set
   bit pressure_go = 1'b0;
   bit pressure_done = 1'b0;
   int idle_cycles = 0;

   stx_etx_packet_deframer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_data_index (rsp_data_index),
      .rsp_command    (rsp_command),
      .rsp_option     (rsp_option),
      .rsp_length     (rsp_length),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   sedf_frame_checker frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_data_index (rsp_data_index),
      .rsp_command    (rsp_command),
      .rsp_option     (rsp_option),
      .rsp_length     (rsp_length),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Offer one req beat and hold it until accepted. Called at a falling edge and
   // returns at the falling edge after acceptance, with valid still high so that
   // back-to-back beats need no second assignment in one step.
   task automatic send_beat(input logic act, input logic [7:0] b);
      while (!no_idle && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // ticks carry a random byte that the parser must ignore
   task automatic send_ticks(input int n);
      repeat (n) send_beat(ACT_TICK, 8'($urandom));
   endtask

   // one frame byte, now and then preceded by a short run of ticks
   task automatic frame_byte(input logic [7:0] b);
      if ($urandom_range(0, 99) < tick_pct) send_ticks($urandom_range(1, tick_span));
      send_beat(ACT_BYTE, b);
      byte_beats++;
   endtask

   // Build and send one frame. An oversized length sends the header only, since
   // the parser gives up after the high length byte. A cut frame stops early and,
   // where the timeout is short enough, is followed by a pause that aborts it.
   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] opt,
                             input logic [15:0] len, input flaw_type flaw,
                             input bit extreme_data);
      logic [7:0] frame_q[$];
      logic [7:0] sum;
      logic [7:0] d;
      int keep;
      sum = cmd ^ opt ^ len[7:0] ^ len[15:8];
      frame_q.push_back(STX_BYTE);
      frame_q.push_back(cmd);
      frame_q.push_back(opt);
      frame_q.push_back(len[7:0]);
      frame_q.push_back(len[15:8]);
      if (len <= cur_lim) begin
         for (int i = 0; i < len; i++) begin
            d = extreme_data ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
            sum ^= d;
            frame_q.push_back(d);
         end
         frame_q.push_back((flaw == FLAW_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum);
         frame_q.push_back((flaw == FLAW_ETX) ? ETX_BYTE ^ 8'($urandom_range(1, 255))
                                              : ETX_BYTE);
      end
      if (flaw == FLAW_CUT) begin
         keep = $urandom_range(1, frame_q.size() - 1);
         while (frame_q.size() > keep) void'(frame_q.pop_back());
      end
      foreach (frame_q[i]) frame_byte(frame_q[i]);
      if (flaw == FLAW_CUT && cur_timeout <= 64) send_ticks(cur_timeout + 1);
   endtask

   // Write a register once every expected result is out and the parser has had
   // time to finish a beat that gives no result.
   task automatic write_reg(input logic idx, input logic [15:0] val);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] timeout, input logic [10:0] max_len);
      write_reg(CSR_TIMEOUT, timeout);
      write_reg(CSR_MAXLEN, {5'b0, max_len});
      cur_timeout = timeout;
      cur_lim     = (max_len < PAYLOAD_CAP) ? {5'b0, max_len} : {5'b0, PAYLOAD_CAP};
      // with a tiny timeout let tick runs land on both sides of it
      tick_span   = (timeout <= 8) ? timeout + 1 : 3;
   endtask

   // Mostly well-formed frames with random content; the rest is noise, pauses,
   // bad checksums, bad end bytes, oversized lengths and cut frames.
   task automatic random_frames(input int count);
      int goal;
      int r;
      logic [15:0] len;
      flaw_type flaw;
      goal = byte_beats + count;
      while (byte_beats < goal) begin
         if ($urandom_range(0, 99) < 10) send_beat(ACT_BYTE, 8'($urandom));
         // pause of exactly the timeout or one tick more
         if (cur_timeout <= 64 && $urandom_range(0, 99) < 6)
            send_ticks(cur_timeout + $urandom_range(0, 1));
         r = $urandom_range(0, 99);
         if (r < 2) len = 16'hFFFF;
         else if (r < 6) len = cur_lim + 16'($urandom_range(1, 3));
         else if (r < 14 || cur_lim == 16'd0) len = 16'd0;
         else if (r < 18) len = 16'($urandom_range(0, (cur_lim < 64) ? cur_lim : 64));
         else len = 16'($urandom_range(1, (cur_lim < 8) ? cur_lim : 8));
         r = $urandom_range(0, 99);
         if (r < 10) flaw = FLAW_SUM;
         else if (r < 16) flaw = FLAW_ETX;
         else if (r < 22) flaw = FLAW_CUT;
         else flaw = FLAW_NONE;
         send_frame(8'($urandom), 8'($urandom), len, flaw, 1'b0);
      end
   endtask

   // rsp side: random stalls, plus one long hold-off that backs up the block
   initial begin
      int hold;
      hold = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_go && !pressure_done) begin
            hold = PRESSURE_CYCLES;
            pressure_done = 1'b1;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(0, 99) >= 13);
         end
      end
   end

   // end the run if neither channel moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_valid   = 1'b0;
      req_action  = ACT_BYTE;
      req_rx_byte = 8'h00;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_TIMEOUT;
      csr_wr_data = 16'h0000;
      reset       = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at reset settings: a tick and a stray byte while waiting
      // for STX, a zero-length frame with extreme command and option, two data
      // bytes at the extremes ending in a wrong end byte, and a length just over
      // the limit.
      send_beat(ACT_TICK, 8'hFF);
      send_beat(ACT_BYTE, 8'h55);
      send_frame(8'hFF, 8'h00, 16'd0, FLAW_NONE, 1'b1);
      send_frame(8'h00, 8'hFF, 16'd2, FLAW_ETX, 1'b1);
      send_frame(8'h12, 8'h34, 16'd1025, FLAW_NONE, 1'b0);

      // Short timeout: tick runs straddle it, so aborts and stale fields show up.
      // Open with the long rsp hold-off while a full-length frame streams in.
      set_config(16'd3, 11'd16);
      tick_pct = 8;
      pressure_go = 1'b1;
      send_frame(8'($urandom), 8'($urandom), 16'd16, FLAW_NONE, 1'b0);
      random_frames(100);

      // Both extremes at the low end, with no idling on either side.
      no_idle = 1'b1;
      set_config(16'd1, 11'd0);
      random_frames(50);
      no_idle = 1'b0;

      // Reset values again: the largest frame, then one byte too long.
      set_config(TIMEOUT_RESET, MAXLEN_RESET);
      send_frame(8'($urandom), 8'($urandom), 16'd1024, FLAW_NONE, 1'b0);
      send_frame(8'($urandom), 8'($urandom), 16'd1025, FLAW_NONE, 1'b0);
      random_frames(50);

      // Longest timeout: leave a frame open across a tick run far below it, so
      // the next byte continues the partial frame with no abort.
      set_config(16'd65535, 11'd7);
      send_frame(8'($urandom), 8'($urandom), 16'd5, FLAW_CUT, 1'b0);
      send_ticks(20);
      send_beat(ACT_BYTE, STX_BYTE);
      random_frames(50);

      set_config(16'd40, 11'd300);
      random_frames(80);

      // drain, then give a late extra result time to show up
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/sedf_pkg.sv
sv/stx_etx_packet_deframer.sv
test/sedf_frame_checker.sv
test/tb_stx_etx_packet_deframer.sv
